// ===== sv/bxg_pkg.sv =====
// Package for the binary extended GCD core: widths, types and step codes.
`timescale 1ns / 1ps

package bxg_pkg;

   // Operand width and derived widths
   localparam int OPERAND_WIDTH = 32;
   localparam int COEFF_OUT_W   = OPERAND_WIDTH + 1;
   // Working coefficients carry guard bits so sums before halving never wrap
   localparam int COEFF_W       = OPERAND_WIDTH + 3;
   localparam int SHIFT_W       = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0]  operand_type;
   typedef logic signed [COEFF_W-1:0] coeff_type;
   typedef logic [SHIFT_W-1:0]        shift_type;

   localparam coeff_type COEFF_ZERO = '0;
   localparam coeff_type COEFF_ONE  = {{(COEFF_W-1){1'b0}}, 1'b1};

   // Step codes for the shared update unit
   typedef enum logic [1:0] {
      OP_HALVE_U = 2'd0,
      OP_HALVE_V = 2'd1,
      OP_SUB     = 2'd2
   } step_op_type;

   // Working values of the Euclid loop: u = A*x + B*y, v = C*x + D*y
   typedef struct packed {
      operand_type u;
      operand_type v;
      coeff_type   ca;
      coeff_type   cb;
      coeff_type   cc;
      coeff_type   cd;
   } loop_state_type;

endpackage

// ===== sv/bxg_req_if.sv =====
// Request channel interface: operand pair with valid/ready.
`timescale 1ns / 1ps

interface bxg_req_if;
   logic                          valid;
   logic                          ready;
   logic [bxg_pkg::OPERAND_WIDTH-1:0] operand_a;
   logic [bxg_pkg::OPERAND_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// ===== sv/bxg_rsp_if.sv =====
// Response channel interface: gcd, Bezout coefficients and error flag.
`timescale 1ns / 1ps

interface bxg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bxg_pkg::OPERAND_WIDTH-1:0]    gcd_value;
   logic signed [bxg_pkg::OPERAND_WIDTH:0] coeff_a;
   logic signed [bxg_pkg::OPERAND_WIDTH:0] coeff_b;
   logic                                 both_zero_error;

   modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                   output both_zero_error, input ready);
   modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                   input both_zero_error, output ready);
endinterface

// ===== sv/bxg_step_unit.sv =====
// Shared update unit: one halving or one subtract step of the extended Euclid loop.
`timescale 1ns / 1ps

module bxg_step_unit (
   input  bxg_pkg::step_op_type    op,
   input  bxg_pkg::operand_type    x_val,
   input  bxg_pkg::operand_type    y_val,
   input  bxg_pkg::loop_state_type cur,
   output bxg_pkg::loop_state_type nxt
);
   import bxg_pkg::*;

   operand_type s_a;
   operand_type s_b;
   operand_type s_res;
   coeff_type   p;
   coeff_type   q;
   coeff_type   pm;
   coeff_type   qm;
   coeff_type   p_base;
   coeff_type   p_add;
   coeff_type   p_cin;
   coeff_type   q_base;
   coeff_type   q_sub;
   coeff_type   p_res;
   coeff_type   q_res;
   coeff_type   x_half;
   coeff_type   y_half;
   logic        halving;
   logic        pair_odd;
   logic        u_ge_v;

   assign x_half  = {{(COEFF_W-OPERAND_WIDTH+1){1'b0}}, x_val[OPERAND_WIDTH-1:1]};
   assign y_half  = {{(COEFF_W-OPERAND_WIDTH+1){1'b0}}, y_val[OPERAND_WIDTH-1:1]};
   assign u_ge_v  = (cur.u >= cur.v);
   assign halving = (op != OP_SUB);

   // Operand selection for the shared adders
   always_comb begin
      s_a = cur.u;
      s_b = cur.v;
      p   = cur.ca;
      q   = cur.cb;
      pm  = cur.cc;
      qm  = cur.cd;
      unique case (op)
         OP_HALVE_U: begin
            s_a = cur.u;
            p   = cur.ca;
            q   = cur.cb;
         end
         OP_HALVE_V: begin
            s_a = cur.v;
            p   = cur.cc;
            q   = cur.cd;
         end
         OP_SUB: begin
            if (!u_ge_v) begin
               s_a = cur.v;
               s_b = cur.u;
               p   = cur.cc;
               q   = cur.cd;
               pm  = cur.ca;
               qm  = cur.cb;
            end
         end
         default: begin
            s_a = cur.u;
         end
      endcase
   end

   // Shared adders: halve with odd-pair correction, or subtract
   always_comb begin
      pair_odd = p[0] | q[0];
      if (halving) begin
         s_res  = s_a >> 1;
         p_base = p >>> 1;
         p_add  = pair_odd ? y_half : COEFF_ZERO;
         p_cin  = {{(COEFF_W-1){1'b0}}, (pair_odd & p[0])};
         q_base = q >>> 1;
         q_sub  = pair_odd ? x_half : COEFF_ZERO;
      end else begin
         s_res  = s_a - s_b;
         p_base = p;
         p_add  = ~pm;
         p_cin  = COEFF_ONE;
         q_base = q;
         q_sub  = qm;
      end
      p_res = p_base + p_add + p_cin;
      q_res = q_base - q_sub;
   end

   // Write back into the lane that was worked on
   always_comb begin
      nxt = cur;
      unique case (op)
         OP_HALVE_U: begin
            nxt.u  = s_res;
            nxt.ca = p_res;
            nxt.cb = q_res;
         end
         OP_HALVE_V: begin
            nxt.v  = s_res;
            nxt.cc = p_res;
            nxt.cd = q_res;
         end
         OP_SUB: begin
            if (u_ge_v) begin
               nxt.u  = s_res;
               nxt.ca = p_res;
               nxt.cb = q_res;
            end else begin
               nxt.v  = s_res;
               nxt.cc = p_res;
               nxt.cd = q_res;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== sv/binary_extended_gcd_core.sv =====
// Binary extended GCD core: sequencer, loop registers and result register.
// The operands are taken in ST_IDLE; ST_ALIGN strips the common factors of two, one bit at
// a time, and then loads the loop; ST_LOOP performs one halving or subtract step at a time;
// the result is held in ST_DONE until taken.
// Throughput: one item at a time; a new pair is taken only after the result is taken.
// A zero operand gives its result in the cycle after the transfer. Reset clears control.
`timescale 1ns / 1ps

module binary_extended_gcd_core (
   input  logic      clock,
   input  logic      reset,
   bxg_req_if.sink   req_chan,
   bxg_rsp_if.source rsp_chan
);
   import bxg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_LOOP  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   operand_type      x_ff, x_in;
   operand_type      y_ff, y_in;
   shift_type        shift_ff, shift_in;
   loop_state_type   dp_ff, dp_in;
   loop_state_type   dp_nxt;
   operand_type      gcd_ff, gcd_in;
   logic signed [OPERAND_WIDTH:0] ca_ff, ca_in;
   logic signed [OPERAND_WIDTH:0] cb_ff, cb_in;
   logic             err_ff, err_in;
   step_op_type      op;
   logic             req_xfer;
   logic             rsp_xfer;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid & rsp_chan.ready;

   // Step choice: halve u while even, then v, otherwise subtract
   always_comb begin
      if (!dp_ff.u[0]) begin
         op = OP_HALVE_U;
      end else if (!dp_ff.v[0]) begin
         op = OP_HALVE_V;
      end else begin
         op = OP_SUB;
      end
   end

   bxg_step_unit u_step (
      .op    (op),
      .x_val (x_ff),
      .y_val (y_ff),
      .cur   (dp_ff),
      .nxt   (dp_nxt)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      shift_in = shift_ff;
      dp_in    = dp_ff;
      gcd_in   = gcd_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      err_in   = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in     = req_chan.operand_a;
               y_in     = req_chan.operand_b;
               shift_in = '0;
               err_in   = 1'b0;
               ca_in    = '0;
               cb_in    = '0;
               if (req_chan.operand_a == '0 && req_chan.operand_b == '0) begin
                  gcd_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (req_chan.operand_a == '0) begin
                  gcd_in   = req_chan.operand_b;
                  cb_in    = COEFF_OUT_W'(1);
                  state_in = ST_DONE;
               end else if (req_chan.operand_b == '0) begin
                  gcd_in   = req_chan.operand_a;
                  ca_in    = COEFF_OUT_W'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            // strip the common power of two, one bit a cycle
            if ((x_ff[0] | y_ff[0]) == 1'b0) begin
               x_in     = x_ff >> 1;
               y_in     = y_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else begin
               dp_in.u  = x_ff;
               dp_in.v  = y_ff;
               dp_in.ca = COEFF_ONE;
               dp_in.cb = COEFF_ZERO;
               dp_in.cc = COEFF_ZERO;
               dp_in.cd = COEFF_ONE;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            dp_in = dp_nxt;
            if (op == OP_SUB && dp_nxt.u == '0) begin
               gcd_in   = dp_nxt.v << shift_ff;
               ca_in    = dp_nxt.cc[OPERAND_WIDTH:0];
               cb_in    = dp_nxt.cd[OPERAND_WIDTH:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      shift_ff <= shift_in;
      dp_ff    <= dp_in;
      gcd_ff   <= gcd_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
      err_ff   <= err_in;
   end

   assign rsp_chan.valid           = (state_ff == ST_DONE);
   assign rsp_chan.gcd_value       = gcd_ff;
   assign rsp_chan.coeff_a         = ca_ff;
   assign rsp_chan.coeff_b         = cb_ff;
   assign rsp_chan.both_zero_error = err_ff;

`ifndef SYNTHESIS
   // never offering a result while taking operands
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("ready and result valid at once");

   // a transfer in closes the request side
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request side still open after transfer");

   // error result carries all-zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.both_zero_error) |->
      (rsp_chan.gcd_value == '0 && rsp_chan.coeff_a == '0 && rsp_chan.coeff_b == '0))
      else $error("error result with nonzero fields");

   // a normal result never has a zero gcd
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.both_zero_error) |-> (rsp_chan.gcd_value != '0))
      else $error("zero gcd without error");
`endif

endmodule

// ===== bench/bxg_gcd_checker.sv =====
// Channel monitor for the binary extended GCD core: predicts each result and compares it.
`timescale 1ns / 1ps

module bxg_gcd_checker (
   input  logic clock,
   input  logic reset,
   bxg_req_if   req_mon,
   bxg_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_owed
);
   import bxg_pkg::*;

   typedef struct packed {
      operand_type              gcd_value;
      logic [COEFF_OUT_W-1:0]   coeff_a;
      logic [COEFF_OUT_W-1:0]   coeff_b;
      logic                     both_zero_error;
   } gcd_result_type;

   gcd_result_type pending_results[$];
   int mismatches = 0;
   int owed       = 0;

   assign fail_count   = mismatches;
   assign results_owed = owed;

   // One halving step of a coefficient pair; an odd pair is first moved by (+y, -x)
   function automatic logic [127:0] halve_pair(longint p, longint q, longint x, longint y);
      if (((p | q) & 1) == 0) begin
         return {p >>> 1, q >>> 1};
      end
      return {(p >>> 1) + (y >>> 1) + (p & 1), (q >>> 1) - (x >>> 1)};
   endfunction

   // Binary extended Euclid: v = cc*x + cd*y holds through the loop
   function automatic gcd_result_type predict_gcd(operand_type opa, operand_type opb);
      gcd_result_type r;
      longint x, y, u, v, ca, cb, cc, cd;
      int twos;
      r = '0;
      if (opa == '0 && opb == '0) begin
         r.both_zero_error = 1'b1;
      end else if (opa == '0) begin
         r.gcd_value = opb;
         r.coeff_b   = COEFF_OUT_W'(1);
      end else if (opb == '0) begin
         r.gcd_value = opa;
         r.coeff_a   = COEFF_OUT_W'(1);
      end else begin
         x    = longint'(opa);
         y    = longint'(opb);
         twos = 0;
         // strip the common power of two
         while (((x | y) & 1) == 0) begin
            x    = x >>> 1;
            y    = y >>> 1;
            twos = twos + 1;
         end
         u  = x;
         v  = y;
         ca = 1;
         cb = 0;
         cc = 0;
         cd = 1;
         do begin
            while ((u & 1) == 0) begin
               u        = u >>> 1;
               {ca, cb} = halve_pair(ca, cb, x, y);
            end
            while ((v & 1) == 0) begin
               v        = v >>> 1;
               {cc, cd} = halve_pair(cc, cd, x, y);
            end
            if (u >= v) begin
               u  = u - v;
               ca = ca - cc;
               cb = cb - cd;
            end else begin
               v  = v - u;
               cc = cc - ca;
               cd = cd - cb;
            end
         end while (u != 0);
         r.gcd_value = operand_type'(v << twos);
         r.coeff_a   = cc[COEFF_OUT_W-1:0];
         r.coeff_b   = cd[COEFF_OUT_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches = mismatches + 1;
      $display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Sample both channels at the rising edge; queue on request, compare on response
   always @(posedge clock) begin
      gcd_result_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            pending_results.push_back(predict_gcd(req_mon.operand_a, req_mon.operand_b));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transfer with nothing pending",
                               64'(rsp_mon.gcd_value), 64'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.gcd_value !== want.gcd_value)
                  report_mismatch("gcd_value", 64'(rsp_mon.gcd_value), 64'(want.gcd_value));
               if (rsp_mon.coeff_a !== want.coeff_a)
                  report_mismatch("coeff_a", 64'(rsp_mon.coeff_a), 64'(want.coeff_a));
               if (rsp_mon.coeff_b !== want.coeff_b)
                  report_mismatch("coeff_b", 64'(rsp_mon.coeff_b), 64'(want.coeff_b));
               if (rsp_mon.both_zero_error !== want.both_zero_error)
                  report_mismatch("both_zero_error", 64'(rsp_mon.both_zero_error),
                                  64'(want.both_zero_error));
            end
         end
         owed = pending_results.size();
      end
   end

endmodule

// ===== bench/tb_binary_extended_gcd_core.sv =====
// Testbench top for the binary extended GCD core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_binary_extended_gcd_core;
   import bxg_pkg::*;

   localparam int          IDLE_LIMIT   = 3000;   // cycles without any transfer
   localparam int          RANDOM_ITEMS = 650;
   localparam operand_type ALL_ONES     = '1;
   localparam operand_type TOP_BIT      = operand_type'(1) << (OPERAND_WIDTH - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_took = 1'b0;
   int   idle_cycles = 0;
   int   ready_run = 0;
   logic ready_level = 1'b0;
   int   fail_count;
   int   results_owed;

   bxg_req_if req_bus ();
   bxg_rsp_if rsp_bus ();

   binary_extended_gcd_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   bxg_gcd_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Request transfer flag sampled at the rising edge, read by the driver at the falling edge
   always @(posedge clock) begin
      req_took <= req_bus.valid && req_bus.ready;
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side: steady runs, long stalls and choppy stretches
   always @(negedge clock) begin
      if (ready_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_level = 1'b1;
               ready_run   = $urandom_range(20, 300);
            end
            1: begin
               ready_level = 1'b0;
               ready_run   = $urandom_range(1, 60);
            end
            default: begin
               ready_level = 1'($urandom_range(0, 1));
               ready_run   = $urandom_range(1, 4);
            end
         endcase
      end
      ready_run     = ready_run - 1;
      rsp_bus.ready = reset ? 1'b0 : ready_level;
   end

   // Present one operand pair and hold it until the transfer
   task automatic offer_pair(operand_type a, operand_type b);
      req_bus.valid     = 1'b1;
      req_bus.operand_a = a;
      req_bus.operand_b = b;
      do @(negedge clock); while (!req_took);
   endtask

   task automatic idle_gap(int cycles);
      req_bus.valid = 1'b0;
      repeat (cycles) begin
         req_bus.operand_a = operand_type'($urandom);
         req_bus.operand_b = operand_type'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   function automatic operand_type pick_operand(int mode);
      int w;
      case (mode)
         0: return operand_type'($urandom);
         1: begin
            w = $urandom_range(1, OPERAND_WIDTH);
            return operand_type'($urandom) & (ALL_ONES >> (OPERAND_WIDTH - w));
         end
         2: return operand_type'($urandom_range(0, 255));
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return operand_type'(1);
               2: return ALL_ONES;
               3: return TOP_BIT;
               4: return ALL_ONES - 1;
               default: return operand_type'($urandom);
            endcase
         end
      endcase
   endfunction

   initial begin
      operand_type a, b;
      int burst_left;
      int k;
      req_bus.valid     = 1'b0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero operands, extremes, powers of two, common factors, ordering
      offer_pair('0, '0);
      offer_pair('0, ALL_ONES);
      offer_pair(ALL_ONES, '0);
      offer_pair('0, operand_type'(1));
      offer_pair(operand_type'(1), '0);
      offer_pair(operand_type'(1), operand_type'(1));
      offer_pair(ALL_ONES, ALL_ONES);
      offer_pair(ALL_ONES, operand_type'(1));
      offer_pair(operand_type'(1), ALL_ONES);
      offer_pair(ALL_ONES, ALL_ONES - 1);
      offer_pair(TOP_BIT, TOP_BIT);
      offer_pair(TOP_BIT, operand_type'(32));
      offer_pair(TOP_BIT, operand_type'(3));
      offer_pair(TOP_BIT, ALL_ONES);
      offer_pair(operand_type'(12), operand_type'(18));
      offer_pair(operand_type'(48), operand_type'(18));
      offer_pair(operand_type'(6), operand_type'(4));
      offer_pair(operand_type'(4), operand_type'(6));
      offer_pair(operand_type'(7), operand_type'(10));
      offer_pair(operand_type'(10), operand_type'(7));
      offer_pair(operand_type'(32'hFFFF_FFFB), operand_type'(32'hFFFF_FFF1));
      offer_pair(operand_type'(32'hAAAA_AAAA), operand_type'(32'h5555_5555));
      idle_gap(1);
      drain_results();
      idle_gap($urandom_range(0, 20));

      // Random: bursts of pairs with random gaps, held until drained after items 200 and 450
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = pick_operand(0);
               b = pick_operand(0);
            end
            4: begin
               a = pick_operand(1);
               b = pick_operand(1);
            end
            5: begin
               k = $urandom_range(1, OPERAND_WIDTH - 1);
               a = operand_type'($urandom) << k;
               b = operand_type'($urandom) << $urandom_range(k, OPERAND_WIDTH - 1);
               if ($urandom_range(0, 1)) {a, b} = {b, a};
            end
            6: begin
               a = ($urandom_range(0, 7) == 0) ? '0 : pick_operand($urandom_range(0, 3));
               b = '0;
               if ($urandom_range(0, 1)) {a, b} = {b, a};
            end
            7: begin
               a = pick_operand(1);
               b = ($urandom_range(0, 1)) ? a : operand_type'(a * $urandom_range(2, 9));
            end
            8: begin
               a = pick_operand(2);
               b = pick_operand(2);
            end
            default: begin
               a = pick_operand(3);
               b = pick_operand($urandom_range(0, 3));
            end
         endcase
         offer_pair(a, b);

         if (n == 200 || n == 450) begin
            drain_results();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
               0: idle_gap(0);
               1: idle_gap($urandom_range(1, 5));
               2: idle_gap($urandom_range(5, 60));
               default: idle_gap($urandom_range(60, 150));
            endcase
         end
         burst_left = burst_left - 1;
      end

      // Wait for the last results, then let the core sit a while
      drain_results();
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
